FILE: rtl/frmq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the framed ring message queue.
// No dependencies.
package frmq_pkg;

   localparam int RING_WORDS  = 1024;
   localparam int SLACK_WORDS = 4;
   localparam int STORE_DEPTH = RING_WORDS + SLACK_WORDS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [13:0] RING_BYTES_MAX = 14'(RING_WORDS * 8);
   localparam logic [13:0] RING_BYTES_MIN = 14'd32;

   localparam logic [1:0] OP_OPEN  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_BAD   = 2'd3;

   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_BAD_LEN    = 3'd1;
   localparam logic [2:0] STAT_TOO_LARGE  = 3'd2;
   localparam logic [2:0] STAT_EMPTY      = 3'd3;
   localparam logic [2:0] STAT_BAD_LAYOUT = 3'd4;
   localparam logic [2:0] STAT_OVERRUN    = 3'd5;
   localparam logic [2:0] STAT_UNEXPECTED = 3'd6;

   typedef struct packed {
      logic [1:0]  operation;
      logic [13:0] message_bytes;
      logic [63:0] payload_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] payload_out;
      logic [3:0]  valid_bytes;
      logic [62:0] frame_number;
      logic        first_word;
      logic        last_word;
      logic        overrun_flag;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [63:0]       wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SENT,
      ST_LEN,
      ST_SEQ,
      ST_NEXT,
      ST_RLEN,
      ST_RLEN0,
      ST_RSEQ,
      ST_RDATA,
      ST_DONE
   } state_type;

   // header (16 bytes) plus payload, rounded up to whole words
   function automatic logic [15:0] stride_of(input logic [13:0] len);
      logic [15:0] s;
      s = 16'(len) + 16'd23;
      return s & ~16'd7;
   endfunction

   function automatic logic [63:0] byte_mask(input logic [3:0] vb);
      logic [63:0] m;
      for (int i = 0; i < 8; i++) begin
         m[8*i +: 8] = (4'(i) < vb) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   function automatic logic word_in_store(input logic [15:0] pos);
      return 32'(pos[15:3]) < STORE_DEPTH;
   endfunction

   function automatic logic [ADDR_W-1:0] word_addr(input logic [15:0] pos);
      return pos[3 +: ADDR_W];
   endfunction

endpackage

FILE: rtl/frmq_ram.sv
`timescale 1ns / 1ps
// Ring word store: one write port, one read port with registered read data.
// Depends on frmq_pkg.
module frmq_ram
   import frmq_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [63:0] rd_data
);

   logic [63:0] mem [STORE_DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/frmq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the queue: writer and reader pointers, commit steps, frame-start walk.
// Depends on frmq_pkg; drives the frmq_ram request.
module frmq_ctrl
   import frmq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   input  logic        csr_valid,
   input  logic [13:0] csr_data,
   output mem_req_type mem_req,
   input  logic [63:0] mem_rd_data,
   output logic        res_valid,
   output rsp_type     res_data,
   input  logic        res_taken
);

   state_type   state_ff, state_in;
   logic [13:0] sz_ff, sz_in;
   logic [13:0] commit_ff, commit_in;
   logic [13:0] ofp_ff, ofp_in;
   logic [13:0] ofb_ff, ofb_in;
   logic [10:0] wwl_ff, wwl_in;
   logic [10:0] wk_ff, wk_in;
   logic [13:0] wrem_ff, wrem_in;
   logic [62:0] seq_ff, seq_in;
   logic [13:0] rpos_ff, rpos_in;
   logic [62:0] rls_ff, rls_in;
   logic        rsv_ff, rsv_in;
   logic [13:0] rbl_ff, rbl_in;
   logic [13:0] rlen_ff, rlen_in;
   logic        first_ff, first_in;
   logic        oob_ff, oob_in;
   rsp_type     res_ff, res_in;

   logic        accept;
   logic [63:0] rd_eff;
   logic [13:0] start_pos;
   logic        start_empty;
   logic        len_bad, len0_bad, seq_gap;
   logic [62:0] seq_next, rls_next;
   logic [15:0] rd_pos;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;
   assign rd_eff    = oob_ff ? 64'd0 : mem_rd_data;
   assign seq_next  = seq_ff + 63'd1;
   assign rls_next  = rls_ff + 63'd1;

   // shared checks of the frame-start walk
   always_comb begin
      start_pos   = (rpos_ff >= sz_ff) ? 14'd0 : rpos_ff;
      start_empty = (start_pos == commit_ff);
      len_bad  = (rd_eff == 64'd0) || (|rd_eff[63:14]) || (rd_eff[13:0] > sz_ff) ||
                 (stride_of(rd_eff[13:0]) > {2'b00, sz_ff - rpos_ff});
      len0_bad = (rd_eff == 64'd0) || (|rd_eff[63:14]) || (rd_eff[13:0] > sz_ff) ||
                 (stride_of(rd_eff[13:0]) > {2'b00, sz_ff});
      seq_gap  = rsv_ff && (rd_eff[62:0] != rls_next);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  OP_WRITE: state_in = (wwl_ff == 11'd1) ? ST_SENT : ST_DONE;
                  OP_READ: begin
                     if (rbl_ff != 14'd0) state_in = ST_RDATA;
                     else state_in = start_empty ? ST_DONE : ST_RLEN;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SENT:  state_in = ST_LEN;
         ST_LEN:   state_in = ST_SEQ;
         ST_SEQ:   state_in = ST_NEXT;
         ST_NEXT:  state_in = ST_DONE;
         ST_RLEN: begin
            if (len_bad) state_in = (commit_ff == 14'd0) ? ST_DONE : ST_RLEN0;
            else state_in = ST_RSEQ;
         end
         ST_RLEN0: state_in = len0_bad ? ST_DONE : ST_RSEQ;
         ST_RSEQ:  state_in = seq_gap ? ST_DONE : ST_RDATA;
         ST_RDATA: state_in = ST_DONE;
         ST_DONE:  state_in = res_taken ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and memory requests
   always_comb begin
      logic [15:0] st;
      logic [15:0] wpos;
      logic [3:0]  vb;
      logic [15:0] ncommit;
      sz_in     = sz_ff;
      commit_in = commit_ff;
      ofp_in    = ofp_ff;
      ofb_in    = ofb_ff;
      wwl_in    = wwl_ff;
      wk_in     = wk_ff;
      wrem_in   = wrem_ff;
      seq_in    = seq_ff;
      rpos_in   = rpos_ff;
      rls_in    = rls_ff;
      rsv_in    = rsv_ff;
      rbl_in    = rbl_ff;
      rlen_in   = rlen_ff;
      first_in  = first_ff;
      res_in    = res_ff;
      mem_req   = '0;
      rd_pos    = 16'd0;
      st        = 16'd0;
      wpos      = 16'd0;
      vb        = 4'd0;
      ncommit   = 16'd0;

      if (csr_valid) begin
         if (csr_data > RING_BYTES_MAX) sz_in = RING_BYTES_MAX;
         else if (csr_data < RING_BYTES_MIN) sz_in = RING_BYTES_MIN;
         else sz_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               case (req_data.operation)
                  OP_OPEN: begin
                     st = stride_of(req_data.message_bytes);
                     if (req_data.message_bytes == 14'd0) begin
                        res_in.status = STAT_BAD_LEN;
                     end else if (req_data.message_bytes >= sz_ff) begin
                        res_in.status = STAT_TOO_LARGE;
                     end else begin
                        if (commit_ff >= sz_ff || st > {2'b00, sz_ff - commit_ff}) ofp_in = 14'd0;
                        else ofp_in = commit_ff;
                        ofb_in  = req_data.message_bytes;
                        wrem_in = req_data.message_bytes;
                        wwl_in  = 11'((15'(req_data.message_bytes) + 15'd7) >> 3);
                        wk_in   = 11'd0;
                        res_in.frame_number = seq_next;
                     end
                  end
                  OP_WRITE: begin
                     if (wwl_ff == 11'd0) begin
                        res_in.status = STAT_UNEXPECTED;
                     end else begin
                        vb   = (wrem_ff >= 14'd8) ? 4'd8 : wrem_ff[3:0];
                        wpos = 16'(ofp_ff) + 16'd16 + {2'b00, wk_ff, 3'b000};
                        mem_req.wr_en   = word_in_store(wpos);
                        mem_req.wr_addr = word_addr(wpos);
                        mem_req.wr_data = req_data.payload_in & byte_mask(vb);
                        wwl_in  = wwl_ff - 11'd1;
                        wk_in   = wk_ff + 11'd1;
                        wrem_in = wrem_ff - 14'(vb);
                        res_in.valid_bytes  = vb;
                        res_in.frame_number = seq_next;
                        res_in.first_word   = (wk_ff == 11'd0);
                        res_in.last_word    = (wwl_ff == 11'd1);
                     end
                  end
                  OP_READ: begin
                     if (rbl_ff == 14'd0) begin
                        if (rpos_ff >= sz_ff) begin
                           rpos_in = 14'd0;
                           rsv_in  = 1'b0;
                        end
                        first_in = 1'b1;
                        if (start_empty) begin
                           res_in.status = STAT_EMPTY;
                        end else begin
                           rd_pos        = 16'(start_pos);
                           mem_req.rd_en = 1'b1;
                        end
                     end else begin
                        first_in      = 1'b0;
                        rd_pos        = 16'(rpos_ff);
                        mem_req.rd_en = 1'b1;
                     end
                  end
                  default: res_in.status = STAT_UNEXPECTED;
               endcase
            end
         end
         ST_SENT: begin
            // wrapped frame: leave a zero sentinel at the old commit point
            wpos = 16'(commit_ff);
            mem_req.wr_en   = (ofp_ff == 14'd0) && (commit_ff != 14'd0) &&
                              (commit_ff < sz_ff) && word_in_store(wpos);
            mem_req.wr_addr = word_addr(wpos);
            mem_req.wr_data = 64'd0;
         end
         ST_LEN: begin
            wpos = 16'(ofp_ff);
            mem_req.wr_en   = word_in_store(wpos);
            mem_req.wr_addr = word_addr(wpos);
            mem_req.wr_data = 64'(ofb_ff);
         end
         ST_SEQ: begin
            seq_in = seq_next;
            wpos = 16'(ofp_ff) + 16'd8;
            mem_req.wr_en   = word_in_store(wpos);
            mem_req.wr_addr = word_addr(wpos);
            mem_req.wr_data = {1'b0, seq_next};
         end
         ST_NEXT: begin
            ncommit   = 16'(ofp_ff) + stride_of(ofb_ff);
            commit_in = ncommit[13:0];
            mem_req.wr_en   = word_in_store(ncommit);
            mem_req.wr_addr = word_addr(ncommit);
            mem_req.wr_data = 64'd0;
         end
         ST_RLEN: begin
            if (len_bad) begin
               rpos_in = 14'd0;
               if (commit_ff == 14'd0) begin
                  res_in.status = STAT_EMPTY;
               end else begin
                  rd_pos        = 16'd0;
                  mem_req.rd_en = 1'b1;
               end
            end else begin
               rlen_in       = rd_eff[13:0];
               rd_pos        = 16'(rpos_ff) + 16'd8;
               mem_req.rd_en = 1'b1;
            end
         end
         ST_RLEN0: begin
            if (len0_bad) begin
               res_in.status = STAT_BAD_LAYOUT;
            end else begin
               rlen_in       = rd_eff[13:0];
               rd_pos        = 16'd8;
               mem_req.rd_en = 1'b1;
            end
         end
         ST_RSEQ: begin
            rsv_in = 1'b1;
            if (seq_gap) begin
               rpos_in = commit_ff;
               rls_in  = seq_ff;
               res_in.status       = STAT_OVERRUN;
               res_in.overrun_flag = 1'b1;
            end else begin
               rls_in        = rd_eff[62:0];
               rbl_in        = rlen_ff;
               rd_pos        = 16'(rpos_ff) + 16'd16;
               mem_req.rd_en = 1'b1;
            end
         end
         ST_RDATA: begin
            vb      = (rbl_ff >= 14'd8) ? 4'd8 : rbl_ff[3:0];
            rbl_in  = rbl_ff - 14'(vb);
            rpos_in = rpos_ff + (first_ff ? 14'd24 : 14'd8);
            res_in.payload_out  = rd_eff & byte_mask(vb);
            res_in.valid_bytes  = vb;
            res_in.frame_number = rls_ff;
            res_in.first_word   = first_ff;
            res_in.last_word    = (rbl_ff == 14'(vb));
         end
         default: begin
         end
      endcase

      // reads outside the store return zero
      mem_req.rd_addr = word_addr(rd_pos);
      oob_in = !word_in_store(rd_pos);
      mem_req.rd_en = mem_req.rd_en && !oob_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sz_ff     <= RING_BYTES_MAX;
         commit_ff <= '0;
         ofp_ff    <= '0;
         ofb_ff    <= '0;
         wwl_ff    <= '0;
         wk_ff     <= '0;
         wrem_ff   <= '0;
         seq_ff    <= '0;
         rpos_ff   <= '0;
         rls_ff    <= '0;
         rsv_ff    <= 1'b0;
         rbl_ff    <= '0;
         first_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sz_ff     <= sz_in;
         commit_ff <= commit_in;
         ofp_ff    <= ofp_in;
         ofb_ff    <= ofb_in;
         wwl_ff    <= wwl_in;
         wk_ff     <= wk_in;
         wrem_ff   <= wrem_in;
         seq_ff    <= seq_in;
         rpos_ff   <= rpos_in;
         rls_ff    <= rls_in;
         rsv_ff    <= rsv_in;
         rbl_ff    <= rbl_in;
         first_ff  <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      rlen_ff <= rlen_in;
      oob_ff  <= oob_in;
      res_ff  <= res_in;
   end

`ifndef SYNTHESIS
   a_wr_in_store: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (32'(mem_req.wr_addr) < STORE_DEPTH))
      else $error("ring write outside the store");

   a_words_left: assert property (@(posedge clock) disable iff (reset)
      15'(wwl_ff) == ((15'(wrem_ff) + 15'd7) >> 3))
      else $error("writer word count and byte count disagree");

   a_read_before_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RLEN || state_ff == ST_RLEN0 || state_ff == ST_RSEQ ||
       state_ff == ST_RDATA) |-> $past(state_ff != ST_DONE))
      else $error("read data used without a preceding read step");

   a_commit_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SENT) |=> (state_ff == ST_LEN) ##1 (state_ff == ST_SEQ)
      ##1 (state_ff == ST_NEXT))
      else $error("commit sequence broken");
`endif

endmodule

FILE: rtl/framed_ring_message_queue.sv
`timescale 1ns / 1ps
// Accept to result on rsp: an open or a payload word goes straight to the result, the
// last word adding sentinel, length, sequence and commit steps; a read inside a frame
// takes a data step, a read at a frame start a length, sequence and data walk.
// One transaction at a time, set by the serial accesses to the single ring memory.
// Synchronous reset zeroes pointers and counters; the ring contents are not cleared.
module framed_ring_message_queue
   import frmq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [13:0] csr_data
);

   mem_req_type mem_req;
   logic [63:0] mem_rd_data;
   logic        res_valid;
   rsp_type     res_data;
   logic        res_taken;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   assign csr_ready = 1'b1;

   frmq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .res_taken   (res_taken)
   );

   frmq_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   // output register frees the sequencer as soon as a result is loaded
   assign res_taken    = res_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_taken || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_taken) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: test/tb_framed_ring_message_queue.sv
`timescale 1ns / 1ps
// Testbench for framed_ring_message_queue: queue-fed driver, clocked monitor, in-order
// scoreboard against a behavioral model of the ring, writer and reader. Uses frmq_pkg.
module tb_framed_ring_message_queue;
   import frmq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [13:0] csr_data = '0;

   framed_ring_message_queue u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      gap_pct = 0;
   int      stall_pct = 0;

   // model state
   logic [63:0] ring_words [0:STORE_DEPTH-1];
   int unsigned m_commit, m_open_pos, m_open_bytes, m_words_left;
   logic [62:0] m_seq;
   int unsigned m_rd_pos, m_rd_left;
   logic [62:0] m_rd_seq;
   logic        m_rd_seq_ok;
   int unsigned m_ring_bytes;

   function automatic int unsigned ring_span();
      int unsigned s;
      s = m_ring_bytes;
      if (s > RING_WORDS * 8) s = RING_WORDS * 8;
      if (s < 32) s = 32;
      return s;
   endfunction

   function automatic int unsigned frame_stride(int unsigned len);
      return (16 + len + 7) & ~32'd7;
   endfunction

   function automatic logic [63:0] keep_bytes(int unsigned vb);
      return vb >= 8 ? '1 : ((64'd1 << (8 * vb)) - 64'd1);
   endfunction

   function automatic logic [63:0] ring_load(int unsigned pos);
      return (pos >> 3) < STORE_DEPTH ? ring_words[pos >> 3] : 64'd0;
   endfunction

   function automatic void ring_store(int unsigned pos, logic [63:0] v);
      if ((pos >> 3) < STORE_DEPTH) ring_words[pos >> 3] = v;
   endfunction

   function automatic rsp_type read_frame_head(int unsigned sz);
      rsp_type     r;
      logic [63:0] len;
      logic [63:0] seq_word;
      logic [62:0] seq;
      int unsigned vb;
      r = '0;
      if (m_rd_pos >= sz) begin
         m_rd_pos = 0;
         m_rd_seq_ok = 1'b0;
      end
      if (m_rd_pos == m_commit) begin
         r.status = STAT_EMPTY;
         return r;
      end
      len = ring_load(m_rd_pos);
      if (len == 0 || len > sz || frame_stride(32'(len)) > sz - m_rd_pos) begin
         m_rd_pos = 0;
         if (m_commit == 0) begin
            r.status = STAT_EMPTY;
            return r;
         end
         len = ring_load(0);
         if (len == 0 || len > sz || frame_stride(32'(len)) > sz) begin
            r.status = STAT_BAD_LAYOUT;
            return r;
         end
      end
      seq_word = ring_load(m_rd_pos + 8);
      seq = seq_word[62:0];
      if (m_rd_seq_ok && seq != m_rd_seq + 63'd1) begin
         m_rd_pos = m_commit;
         m_rd_seq = m_seq;
         m_rd_seq_ok = 1'b1;
         r.status = STAT_OVERRUN;
         r.overrun_flag = 1'b1;
         return r;
      end
      m_rd_seq = seq;
      m_rd_seq_ok = 1'b1;
      vb = len < 8 ? 32'(len) : 8;
      r.payload_out = ring_load(m_rd_pos + 16) & keep_bytes(vb);
      r.valid_bytes = 4'(vb);
      r.frame_number = seq;
      r.first_word = 1'b1;
      m_rd_left = 32'(len) - vb;
      r.last_word = m_rd_left == 0;
      m_rd_pos += 24;
      return r;
   endfunction

   function automatic rsp_type predict_response(req_type q);
      rsp_type     r;
      int unsigned sz, len, k, rem, vb, p;
      r = '0;
      sz = ring_span();
      case (q.operation)
         OP_OPEN: begin
            len = 32'(q.message_bytes);
            if (len == 0) r.status = STAT_BAD_LEN;
            else if (len >= sz) r.status = STAT_TOO_LARGE;
            else begin
               if (m_commit >= sz || frame_stride(len) > sz - m_commit) m_open_pos = 0;
               else m_open_pos = m_commit;
               m_open_bytes = len;
               m_words_left = (len + 7) >> 3;
               r.frame_number = m_seq + 63'd1;
            end
         end
         OP_WRITE: begin
            if (m_words_left == 0) r.status = STAT_UNEXPECTED;
            else begin
               k = ((m_open_bytes + 7) >> 3) - m_words_left;
               rem = m_open_bytes - k * 8;
               vb = rem < 8 ? rem : 8;
               ring_store(m_open_pos + 16 + k * 8, q.payload_in & keep_bytes(vb));
               m_words_left--;
               r.valid_bytes = 4'(vb);
               r.frame_number = m_seq + 63'd1;
               r.first_word = k == 0;
               if (m_words_left == 0) begin
                  p = m_open_pos;
                  r.last_word = 1'b1;
                  // wrapped: leave a zero sentinel where the writer stood
                  if (p == 0 && m_commit > 0 && m_commit < sz) ring_store(m_commit, 64'd0);
                  m_seq = m_seq + 63'd1;
                  ring_store(p, 64'(m_open_bytes));
                  ring_store(p + 8, {1'b0, m_seq});
                  m_commit = p + frame_stride(m_open_bytes);
                  ring_store(m_commit, 64'd0);
               end
            end
         end
         OP_READ: begin
            if (m_rd_left == 0) r = read_frame_head(sz);
            else begin
               vb = m_rd_left < 8 ? m_rd_left : 8;
               r.payload_out = ring_load(m_rd_pos) & keep_bytes(vb);
               r.valid_bytes = 4'(vb);
               r.frame_number = m_rd_seq;
               m_rd_left -= vb;
               r.last_word = m_rd_left == 0;
               m_rd_pos += 8;
            end
         end
         default: r.status = STAT_UNEXPECTED;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_rsps.push_back(predict_response(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= gap_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_data, '0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.payload_out != want.payload_out)
               report_mismatch("payload_out", rsp_data.payload_out, want.payload_out);
            if (rsp_data.valid_bytes != want.valid_bytes)
               report_mismatch("valid_bytes", rsp_data.valid_bytes, want.valid_bytes);
            if (rsp_data.frame_number != want.frame_number)
               report_mismatch("frame_number", rsp_data.frame_number, want.frame_number);
            if (rsp_data.first_word != want.first_word)
               report_mismatch("first_word", rsp_data.first_word, want.first_word);
            if (rsp_data.last_word != want.last_word)
               report_mismatch("last_word", rsp_data.last_word, want.last_word);
            if (rsp_data.overrun_flag != want.overrun_flag)
               report_mismatch("overrun_flag", rsp_data.overrun_flag, want.overrun_flag);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic void push_req(logic [1:0] op, int unsigned len, logic [63:0] data);
      req_type q;
      q.operation = op;
      q.message_bytes = 14'(len);
      q.payload_in = data;
      pending_reqs.push_back(q);
   endfunction

   task automatic write_ring_bytes(int unsigned v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= 14'(v);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      m_ring_bytes = v;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // mostly well-formed frames interleaved with reads, plus noise
   task automatic fill_random(int n);
      int total, sel, len, words, cap, i;
      int unsigned sz;
      total = 0;
      sz = ring_span();
      while (total < n) begin
         sel = $urandom_range(99);
         if (sel < 60) begin
            cap = sz - 1 < 64 ? sz - 1 : 64;
            if ($urandom_range(9) < 2) cap = sz - 1 < 600 ? sz - 1 : 600;
            len = $urandom_range(cap, 1);
            words = (len + 7) / 8;
            // occasionally abandon the frame partway through
            if ($urandom_range(9) == 0) words = $urandom_range(words - 1, 0);
            push_req(OP_OPEN, len, rand_word());
            total++;
            for (i = 0; i < words; i++) begin
               push_req(OP_WRITE, $urandom_range(16383), rand_word());
               total++;
               if ($urandom_range(99) < 25) begin
                  push_req(OP_READ, $urandom_range(16383), rand_word());
                  total++;
               end
            end
         end else if (sel < 85) begin
            repeat ($urandom_range(6, 1)) begin
               push_req(OP_READ, $urandom_range(16383), rand_word());
               total++;
            end
         end else if (sel < 92) begin
            push_req(OP_OPEN, $urandom_range(1) ? 0 : $urandom_range(16383, sz), rand_word());
            total++;
         end else if (sel < 96) begin
            push_req(OP_WRITE, $urandom_range(16383), rand_word());
            total++;
         end else begin
            push_req(OP_BAD, $urandom_range(16383), rand_word());
            total++;
         end
      end
   endtask

   initial begin
      int seg;
      int unsigned ring_settings[4];
      ring_settings = '{32, 16383, 200, 8192};
      for (int i = 0; i < STORE_DEPTH; i++) ring_words[i] = '0;
      m_commit = 0; m_open_pos = 0; m_open_bytes = 0; m_words_left = 0; m_seq = '0;
      m_rd_pos = 0; m_rd_left = 0; m_rd_seq = '0; m_rd_seq_ok = 1'b0;
      m_ring_bytes = 8192;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_ring_bytes(8192);

      // directed: empty ring, bad lengths, stray words, short and dropped frames
      push_req(OP_READ, 0, '0);
      push_req(OP_OPEN, 0, '0);
      push_req(OP_OPEN, 8192, '0);
      push_req(OP_OPEN, 16383, '1);
      push_req(OP_WRITE, 0, '1);
      push_req(OP_BAD, 16383, '1);
      push_req(OP_OPEN, 1, '0);
      push_req(OP_WRITE, 0, '1);
      push_req(OP_READ, 0, '0);
      push_req(OP_READ, 0, '0);
      push_req(OP_OPEN, 20, '0);
      push_req(OP_WRITE, 0, 64'h0123456789abcdef);
      push_req(OP_OPEN, 13, '0);
      push_req(OP_WRITE, 0, '1);
      push_req(OP_WRITE, 0, '1);
      push_req(OP_READ, 0, '0);
      push_req(OP_READ, 0, '0);
      push_req(OP_READ, 0, '0);
      push_req(OP_OPEN, 8191, '0);
      push_req(OP_OPEN, 8, '0);
      push_req(OP_WRITE, 0, 64'h00ff00ff00ff00ff);
      push_req(OP_READ, 0, '0);
      drain();

      for (seg = 0; seg < 4; seg++) begin
         write_ring_bytes(ring_settings[seg]);
         gap_pct = seg == 0 ? 32 : (seg == 1 ? 60 : 0);
         stall_pct = seg == 0 ? 60 : (seg == 1 ? 32 : 0);
         fill_random(320);
         drain();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/frmq_pkg.sv
rtl/frmq_ram.sv
rtl/frmq_ctrl.sv
rtl/framed_ring_message_queue.sv
test/tb_framed_ring_message_queue.sv
